>>> sv/ssgu_pkg.sv
// ----------------------------------------------------------------------------
// ssgu_pkg: shared definitions of the single-step growth update block
// Field widths, operation and result codes, configuration register indexes,
// the queue item kind and the configuration bundle handed to the back end.
// ----------------------------------------------------------------------------
package ssgu_pkg;

	// Fixed port widths.
	localparam int SITE_W     = 13;
	localparam int RAND_W     = 16;
	localparam int IN_H_W     = 32;
	localparam int OUT_H_W    = 32;
	localparam int PROB_REG_W = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int OP_W       = 2;
	localparam int CHG_W      = 2;

	// Parameter defaults.
	localparam int DEF_SITES       = 8192;
	localparam int DEF_HEIGHT_BITS = 32;
	localparam int DEF_PROB_BITS   = 16;

	// Depth of the queue between front and back end.
	localparam int QUEUE_DEPTH = 2;

	// Operation codes on the op port.
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	// Codes on the change port.
	localparam logic [CHG_W-1:0] CHG_NONE = 2'd0;
	localparam logic [CHG_W-1:0] CHG_RISE = 2'd1;
	localparam logic [CHG_W-1:0] CHG_FALL = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_CLEAN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_DIS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FALL_CLEAN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FALL_DIS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIS_EN     = 3'd4;

	// Class of an item as the front end sorts it.
	typedef enum logic [1:0] {
		KIND_UPDATE,
		KIND_WRITE,
		KIND_READ
	} item_kind_t;

	localparam int KIND_W = 2;

	// Configuration values seen by the back end.
	typedef struct packed {
		logic [PROB_REG_W-1:0] rise_clean;
		logic [PROB_REG_W-1:0] rise_dis;
		logic [PROB_REG_W-1:0] fall_clean;
		logic [PROB_REG_W-1:0] fall_dis;
		logic                  dis_en;
	} cfg_t;

	// Number of restoring steps needed to bring a site index into range:
	// one step for each shifted copy of the ring size that still fits below
	// the full range of the site port.
	function automatic int red_steps(input longint sites);
		int n;
		n = 0;
		for (int k = 0; k < SITE_W; k++) begin
			if ((sites << k) < (longint'(1) << SITE_W))
				n = k + 1;
		end
		return n;
	endfunction

endpackage

>>> sv/ssgu_queue.sv
// ----------------------------------------------------------------------------
// ssgu_queue: short item queue between front and back end
// A small register file queue with a fill count; push only when not full,
// pop only when not empty. The head item is shown without delay.
// ----------------------------------------------------------------------------
module ssgu_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty
);

	localparam int DEPTH = ssgu_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> sv/ssgu_front.sv
// ----------------------------------------------------------------------------
// ssgu_front: item intake and classification
// Accepts items, sorts them into update, write and read, sign-extends the
// write height and brings the site index into the ring, then queues them.
// ----------------------------------------------------------------------------
module ssgu_front #(
	parameter int SITES       = ssgu_pkg::DEF_SITES,
	parameter int HEIGHT_BITS = ssgu_pkg::DEF_HEIGHT_BITS,
	parameter int ITEM_W      = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ssgu_pkg::OP_W-1:0]         op,
	input  logic [ssgu_pkg::SITE_W-1:0]       site,
	input  logic [ssgu_pkg::RAND_W-1:0]       random_frac,
	input  logic signed [ssgu_pkg::IN_H_W-1:0] new_height,
	input  logic                              new_disorder,
	input  logic                              q_full,
	output logic                              q_push,
	output logic [ITEM_W-1:0]                 q_data
);

	localparam int SB        = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int SW        = ssgu_pkg::SITE_W;
	localparam int RED_STEPS = ssgu_pkg::red_steps(longint'(SITES));
	localparam int STEP_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
	localparam logic [31:0] SITES_L = 32'(SITES);

	typedef enum logic {F_IDLE, F_RED} fstate_t;

	fstate_t                         state_q;
	logic [STEP_W-1:0]               step_q;
	logic [SW-1:0]                   red_q;
	ssgu_pkg::item_kind_t            kind_q;
	logic [ssgu_pkg::RAND_W-1:0]     rand_q;
	logic [HEIGHT_BITS-1:0]          nh_q;
	logic                            nd_q;

	logic                            accept;
	logic [SW-1:0]                   div_v;
	logic [SW-1:0]                   red_next;
	logic [HEIGHT_BITS-1:0]          nh_ext;

	function automatic ssgu_pkg::item_kind_t classify(input logic [ssgu_pkg::OP_W-1:0] code);
		case (code)
			ssgu_pkg::OP_UPDATE: return ssgu_pkg::KIND_UPDATE;
			ssgu_pkg::OP_WRITE:  return ssgu_pkg::KIND_WRITE;
			default:             return ssgu_pkg::KIND_READ;
		endcase
	endfunction

	assign busy   = (state_q != F_IDLE) || q_full;
	assign accept = start && !busy;
	assign nh_ext = HEIGHT_BITS'(new_height);

	// One restoring step: subtract the ring size shifted by the step number.
	assign div_v    = SW'(SITES_L << step_q);
	assign red_next = (red_q >= div_v) ? red_q - div_v : red_q;

	always_comb begin
		q_push = 1'b0;
		q_data = {classify(op), SB'(site), random_frac, nh_ext, new_disorder};
		case (state_q)
			F_IDLE: begin
				q_push = accept && (RED_STEPS == 0);
			end
			F_RED: begin
				q_push = (step_q == '0);
				q_data = {kind_q, SB'(red_next), rand_q, nh_q, nd_q};
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						kind_q <= classify(op);
						red_q  <= site;
						rand_q <= random_frac;
						nh_q   <= nh_ext;
						nd_q   <= new_disorder;
						if (RED_STEPS != 0) begin
							state_q <= F_RED;
							step_q  <= STEP_W'(RED_STEPS - 1);
						end
					end
				end
				F_RED: begin
					red_q <= red_next;
					if (step_q == '0)
						state_q <= F_IDLE;
					else
						step_q <= step_q - 1'b1;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/ssgu_back.sv
// ----------------------------------------------------------------------------
// ssgu_back: surface store and update execution
// Holds the height ring and disorder map, pops queued items, reads the site
// and its neighbors, applies the growth rule and presents one result.
// ----------------------------------------------------------------------------
module ssgu_back #(
	parameter int SITES       = ssgu_pkg::DEF_SITES,
	parameter int HEIGHT_BITS = ssgu_pkg::DEF_HEIGHT_BITS,
	parameter int PROB_BITS   = ssgu_pkg::DEF_PROB_BITS,
	parameter int ITEM_W      = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ssgu_pkg::cfg_t                     cfg,
	input  logic                               q_empty,
	input  logic [ITEM_W-1:0]                  q_head,
	output logic                               q_pop,
	output logic                               done,
	output logic signed [ssgu_pkg::OUT_H_W-1:0] height,
	output logic                               site_disorder,
	output logic [ssgu_pkg::CHG_W-1:0]         change
);

	localparam int SB        = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int HB        = HEIGHT_BITS;
	localparam int CMP_W = (PROB_BITS > ssgu_pkg::PROB_REG_W) ? PROB_BITS : ssgu_pkg::PROB_REG_W;
	localparam int KIND_BITS = ssgu_pkg::KIND_W;

	typedef enum logic [1:0] {B_IDLE, B_WAIT, B_EXEC} bstate_t;

	logic [HB-1:0] height_mem [SITES];
	logic          dis_mem    [SITES];

	bstate_t                          state_q;
	ssgu_pkg::item_kind_t             kind_q;
	logic [SB-1:0]                    idx_q;
	logic [ssgu_pkg::RAND_W-1:0]      rand_q;
	logic [HB-1:0]                    hc_q;
	logic [HB-1:0]                    hl_q;
	logic                             dis_q;
	logic [HB-1:0]                    rd0_q;
	logic [HB-1:0]                    rd1_q;
	logic                             drd_q;
	logic                             done_q;
	logic [ssgu_pkg::OUT_H_W-1:0]     height_q;
	logic                             sdis_q;
	logic [ssgu_pkg::CHG_W-1:0]       change_q;

	logic [KIND_BITS-1:0]             h_kind_bits;
	ssgu_pkg::item_kind_t             h_kind;
	logic [SB-1:0]                    h_idx;
	logic [ssgu_pkg::RAND_W-1:0]      h_rand;
	logic [HB-1:0]                    h_nh;
	logic                             h_nd;

	logic [SB-1:0]                    addr0;
	logic [SB-1:0]                    addr1;
	logic                             hwe;
	logic                             dwe;
	logic [SB-1:0]                    waddr;
	logic [HB-1:0]                    wdata;

	logic [HB-1:0]                    sl;
	logic [HB-1:0]                    sr;
	logic                             at_min;
	logic                             at_max;
	logic                             use_dis;
	logic [PROB_BITS-1:0]             r_p;
	logic [CMP_W-1:0]                 r_c;
	logic [CMP_W-1:0]                 p_rise;
	logic [CMP_W-1:0]                 p_fall;
	logic [ssgu_pkg::CHG_W-1:0]       chg;
	logic [HB-1:0]                    h_upd;

	assign {h_kind_bits, h_idx, h_rand, h_nh, h_nd} = q_head;
	assign h_kind = ssgu_pkg::item_kind_t'(h_kind_bits);

	function automatic logic [SB-1:0] left_of(input logic [SB-1:0] i);
		return (i == '0) ? SB'(SITES - 1) : i - 1'b1;
	endfunction

	function automatic logic [SB-1:0] right_of(input logic [SB-1:0] i);
		return (i == SB'(SITES - 1)) ? '0 : i + 1'b1;
	endfunction

	assign q_pop = (state_q == B_IDLE) && !q_empty;

	// Port 0 reads the center site, port 1 first the left, then the right neighbor.
	assign addr0 = h_idx;
	assign addr1 = (state_q == B_IDLE) ? left_of(h_idx) : right_of(idx_q);

	// Growth rule on the center, left and right heights.
	assign sl      = hc_q - hl_q;
	assign sr      = rd1_q - hc_q;
	assign at_min  = (sl == '1) && (sr == HB'(1));
	assign at_max  = (sl == HB'(1)) && (sr == '1);
	assign use_dis = cfg.dis_en && dis_q;
	assign r_p     = PROB_BITS'(rand_q);
	assign r_c     = CMP_W'(r_p);
	assign p_rise  = CMP_W'(use_dis ? cfg.rise_dis : cfg.rise_clean);
	assign p_fall  = CMP_W'(use_dis ? cfg.fall_dis : cfg.fall_clean);

	always_comb begin
		chg   = ssgu_pkg::CHG_NONE;
		h_upd = hc_q;
		if (at_min && (r_c < p_rise)) begin
			chg   = ssgu_pkg::CHG_RISE;
			h_upd = hc_q + HB'(2);
		end else if (at_max && (r_c < p_fall)) begin
			chg   = ssgu_pkg::CHG_FALL;
			h_upd = hc_q - HB'(2);
		end
	end

	always_comb begin
		hwe   = 1'b0;
		dwe   = 1'b0;
		waddr = h_idx;
		wdata = h_nh;
		case (state_q)
			B_IDLE: begin
				hwe = q_pop && (h_kind == ssgu_pkg::KIND_WRITE);
				dwe = hwe;
			end
			B_EXEC: begin
				hwe   = (chg != ssgu_pkg::CHG_NONE);
				waddr = idx_q;
				wdata = h_upd;
			end
			default: begin
				hwe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (hwe)
			height_mem[waddr] <= wdata;
		if (dwe)
			dis_mem[waddr] <= h_nd;
		rd0_q <= height_mem[addr0];
		rd1_q <= height_mem[addr1];
		drd_q <= dis_mem[addr0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						kind_q <= h_kind;
						idx_q  <= h_idx;
						rand_q <= h_rand;
						if (h_kind == ssgu_pkg::KIND_WRITE) begin
							done_q   <= 1'b1;
							height_q <= ssgu_pkg::OUT_H_W'(h_nh);
							sdis_q   <= h_nd;
							change_q <= ssgu_pkg::CHG_NONE;
						end else begin
							state_q <= B_WAIT;
						end
					end
				end
				B_WAIT: begin
					hc_q  <= rd0_q;
					hl_q  <= rd1_q;
					dis_q <= drd_q;
					if (kind_q == ssgu_pkg::KIND_UPDATE) begin
						state_q <= B_EXEC;
					end else begin
						done_q   <= 1'b1;
						height_q <= ssgu_pkg::OUT_H_W'(rd0_q);
						sdis_q   <= drd_q;
						change_q <= ssgu_pkg::CHG_NONE;
						state_q  <= B_IDLE;
					end
				end
				B_EXEC: begin
					done_q   <= 1'b1;
					height_q <= ssgu_pkg::OUT_H_W'(h_upd);
					sdis_q   <= dis_q;
					change_q <= chg;
					state_q  <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign height        = signed'(height_q);
	assign site_disorder = sdis_q;
	assign change        = change_q;

endmodule

>>> sv/single_step_growth_update_top.sv
// ----------------------------------------------------------------------------
// single_step_growth_update_top: single-step surface growth update engine
// Ring of surface heights with per-site disorder bits; update, write and
// read items, one result per item, and a small set of probability registers.
// ----------------------------------------------------------------------------
// Every accepted item produces exactly one result beat, shown on height,
// site_disorder and change for a single cycle while done is high. The
// receiver cannot stall: a result that is not taken in that cycle is gone.
// Items enter when start is high and busy is low, and results leave in the
// order the items went in. In the back end a write is answered from the
// idle state, a read after the wait state and an update after the wait and
// execute states, as the ring memory has two read ports and an update needs
// three heights (center and left first, then right); the result beat is
// registered. Below 8192 SITES the front end runs one restoring step per
// cycle for each power-of-two multiple of SITES that fits in the 13-bit site
// field, which brings the site index into the ring. A two-entry queue between
// the two ends lets the front take the next item while the back is still busy.
// The ring and disorder map are not cleared after reset: read or update a
// site only after it and, for updates, both of its neighbors were written.
// ----------------------------------------------------------------------------
module single_step_growth_update_top #(
	parameter int SITES       = ssgu_pkg::DEF_SITES,
	parameter int HEIGHT_BITS = ssgu_pkg::DEF_HEIGHT_BITS,
	parameter int PROB_BITS   = ssgu_pkg::DEF_PROB_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Item intake.
	input  logic                                start,
	output logic                                busy,
	input  logic [ssgu_pkg::OP_W-1:0]           op,
	input  logic [ssgu_pkg::SITE_W-1:0]         site,
	input  logic [ssgu_pkg::RAND_W-1:0]         random_frac,
	input  logic signed [ssgu_pkg::IN_H_W-1:0]  new_height,
	input  logic                                new_disorder,
	// Configuration writes.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ssgu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssgu_pkg::PROB_REG_W-1:0]     cfg_data,
	// Results.
	output logic                                done,
	output logic signed [ssgu_pkg::OUT_H_W-1:0] height,
	output logic                                site_disorder,
	output logic [ssgu_pkg::CHG_W-1:0]          change
);

	localparam int SB     = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int ITEM_W = ssgu_pkg::KIND_W + SB + ssgu_pkg::RAND_W + HEIGHT_BITS + 1;

	ssgu_pkg::cfg_t    cfg_q;
	logic              q_push;
	logic [ITEM_W-1:0] q_data;
	logic              q_full;
	logic              q_pop;
	logic [ITEM_W-1:0] q_head;
	logic              q_empty;

	// Configuration registers. Writes are always taken; an index past the
	// last register is ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ssgu_pkg::CFG_RISE_CLEAN: cfg_q.rise_clean <= cfg_data;
				ssgu_pkg::CFG_RISE_DIS:   cfg_q.rise_dis   <= cfg_data;
				ssgu_pkg::CFG_FALL_CLEAN: cfg_q.fall_clean <= cfg_data;
				ssgu_pkg::CFG_FALL_DIS:   cfg_q.fall_dis   <= cfg_data;
				ssgu_pkg::CFG_DIS_EN:     cfg_q.dis_en     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The front end sorts items and reduces the site index.
	ssgu_front #(
		.SITES       (SITES),
		.HEIGHT_BITS (HEIGHT_BITS),
		.ITEM_W      (ITEM_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.site         (site),
		.random_frac  (random_frac),
		.new_height   (new_height),
		.new_disorder (new_disorder),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_data)
	);

	ssgu_queue #(
		.W (ITEM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// The back end owns the ring and produces the result beats.
	ssgu_back #(
		.SITES       (SITES),
		.HEIGHT_BITS (HEIGHT_BITS),
		.PROB_BITS   (PROB_BITS),
		.ITEM_W      (ITEM_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.done          (done),
		.height        (height),
		.site_disorder (site_disorder),
		.change        (change)
	);

endmodule

>>> dv/ssgu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssgu_checker: result checker for the single-step growth update block
// Watches the item, configuration and result channels, keeps its own copy of
// the height ring, disorder map and probability registers, and compares each
// result beat with the prediction made when its item was accepted.
// ----------------------------------------------------------------------------
module ssgu_checker
	import ssgu_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [OP_W-1:0]             op,
	input  logic [SITE_W-1:0]           site,
	input  logic [RAND_W-1:0]           random_frac,
	input  logic signed [IN_H_W-1:0]    new_height,
	input  logic                        new_disorder,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [PROB_REG_W-1:0]       cfg_data,
	input  logic                        done,
	input  logic signed [OUT_H_W-1:0]   height,
	input  logic                        site_disorder,
	input  logic [CHG_W-1:0]            change,
	output int                          mismatches,
	output int                          outstanding
);

	// The default ring fills the site field exactly, so neighbor indexes
	// wrap by plain SITE_W-bit arithmetic.
	localparam int RING_SITES = 1 << SITE_W;
	localparam int REPORT_CAP = 40;

	typedef struct {
		logic [SITE_W-1:0]  site;
		logic [OUT_H_W-1:0] height;
		logic               disorder;
		logic [CHG_W-1:0]   change;
	} site_result_t;

	logic [OUT_H_W-1:0]    ring_height [RING_SITES];
	logic                  ring_dis [RING_SITES];
	logic [PROB_REG_W-1:0] rise_clean = '0;
	logic [PROB_REG_W-1:0] rise_dis   = '0;
	logic [PROB_REG_W-1:0] fall_clean = '0;
	logic [PROB_REG_W-1:0] fall_dis   = '0;
	logic                  dis_en     = 1'b0;

	site_result_t awaited_results [$];
	int miss_count = 0;
	int pend_count = 0;

	assign mismatches  = miss_count;
	assign outstanding = pend_count;

	task automatic report_mismatch(input string msg);
		if (miss_count < REPORT_CAP)
			$display("%0t ns: growth update mismatch: %s", $time, msg);
		miss_count++;
	endtask

	// Applies one item to the local surface and returns the result it must produce.
	function automatic site_result_t advance_surface(
		input logic [OP_W-1:0]    kind_op,
		input logic [SITE_W-1:0]  s,
		input logic [RAND_W-1:0]  rf,
		input logic [IN_H_W-1:0]  nh,
		input logic               nd
	);
		site_result_t res;
		logic [SITE_W-1:0]  lft;
		logic [SITE_W-1:0]  rgt;
		logic [OUT_H_W-1:0] hc;
		logic [OUT_H_W-1:0] slope_l;
		logic [OUT_H_W-1:0] slope_r;
		logic               use_dis;
		res.change = CHG_NONE;
		if (kind_op == OP_WRITE) begin
			ring_height[s] = nh;
			ring_dis[s]    = nd;
		end else if (kind_op == OP_UPDATE) begin
			lft     = s - 1'b1;
			rgt     = s + 1'b1;
			hc      = ring_height[s];
			slope_l = hc - ring_height[lft];
			slope_r = ring_height[rgt] - hc;
			use_dis = dis_en && ring_dis[s];
			// A probability of full scale or more beats every 16-bit fraction.
			if (slope_l == '1 && slope_r == 1) begin
				if ({1'b0, rf} < (use_dis ? rise_dis : rise_clean)) begin
					ring_height[s] = hc + 2;
					res.change     = CHG_RISE;
				end
			end else if (slope_l == 1 && slope_r == '1) begin
				if ({1'b0, rf} < (use_dis ? fall_dis : fall_clean)) begin
					ring_height[s] = hc - 2;
					res.change     = CHG_FALL;
				end
			end
		end
		res.site     = s;
		res.height   = ring_height[s];
		res.disorder = ring_dis[s];
		return res;
	endfunction

	always @(posedge clk) begin
		site_result_t want;
		if (arst_n) begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing pending, height %h",
						height));
				end else begin
					want = awaited_results.pop_front();
					if (height !== want.height)
						report_mismatch($sformatf("site %0d height got %h want %h",
							want.site, height, want.height));
					if (site_disorder !== want.disorder)
						report_mismatch($sformatf("site %0d disorder got %b want %b",
							want.site, site_disorder, want.disorder));
					if (change !== want.change)
						report_mismatch($sformatf("site %0d change got %0d want %0d",
							want.site, change, want.change));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RISE_CLEAN: rise_clean = cfg_data;
					CFG_RISE_DIS:   rise_dis   = cfg_data;
					CFG_FALL_CLEAN: fall_clean = cfg_data;
					CFG_FALL_DIS:   fall_dis   = cfg_data;
					CFG_DIS_EN:     dis_en     = cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy)
				awaited_results.push_back(advance_surface(op, site, random_frac,
					new_height, new_disorder));
			pend_count = awaited_results.size();
		end
	end

endmodule

>>> dv/single_step_growth_update_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_step_growth_update_top_test: testbench of the growth update engine
// Drives directed and random update, write and read beats through several
// probability settings and leaves all checking to ssgu_checker, which sits
// beside the block and hands back its mismatch count for the verdict.
// ----------------------------------------------------------------------------
module single_step_growth_update_top_test;
	import ssgu_pkg::*;

	// The watchdog fires after this many cycles in which no beat moves on any
	// channel. The slowest correct stretch is an idle burst or the block
	// latency, so this is far beyond any legal quiet time.
	localparam int STALL_LIMIT   = 2000;
	// Cycles to wait after the last result so that a stray extra beat is seen.
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 305;
	localparam int RING_SITES    = 1 << SITE_W;

	// Op code 3 has no function of its own; the block must treat it as a read.
	localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;
	// Register index with no register behind it; a write there must do nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [OP_W-1:0]             op;
	logic [SITE_W-1:0]           site;
	logic [RAND_W-1:0]           random_frac;
	logic signed [IN_H_W-1:0]    new_height;
	logic                        new_disorder;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [PROB_REG_W-1:0]       cfg_data;
	logic                        done;
	logic signed [OUT_H_W-1:0]   height;
	logic                        site_disorder;
	logic [CHG_W-1:0]            change;
	int                          mismatches;
	int                          outstanding;

	// The ring is not cleared by reset, so the stimulus remembers which sites
	// hold a value and never reads or updates around a site that does not.
	bit                    site_written [RING_SITES];
	logic [SITE_W-1:0]     written_sites [$];
	// Probabilities currently programmed, used to aim fractions at thresholds.
	logic [PROB_REG_W-1:0] cur_prob [4];
	// calm switches off idle bursts for one stretch; quiet for the rest of the run.
	bit                    calm  = 1'b0;
	bit                    quiet = 1'b0;
	int                    stall_cycles = 0;

	single_step_growth_update_top dut (.*);

	ssgu_checker surface_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: any accepted beat on the item, configuration or result
	// channel restarts the count. It also catches results that never arrive.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("single_step_growth_update_top_test failed");
			$finish;
		end
	end

	// Presents one item beat at the falling edge and holds it until the block
	// takes it. start stays high afterward so back-to-back beats need no
	// extra edge; an idle burst, when one is drawn, lowers it.
	task automatic send_item(
		input logic [OP_W-1:0]   kind_op,
		input logic [SITE_W-1:0] s,
		input logic [RAND_W-1:0] rf,
		input logic [IN_H_W-1:0] nh,
		input logic              nd
	);
		@(negedge clk);
		start        <= 1'b1;
		op           <= kind_op;
		site         <= s;
		random_frac  <= rf;
		new_height   <= nh;
		new_disorder <= nd;
		do @(posedge clk); while (busy);
		if (kind_op == OP_WRITE && !site_written[s]) begin
			site_written[s] = 1'b1;
			written_sites.push_back(s);
		end
		if (!calm && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
	endtask

	// Fields that an op does not use are filled with noise: the block must
	// ignore them.
	task automatic write_site(input logic [SITE_W-1:0] s, input logic [IN_H_W-1:0] h,
		input logic d);
		send_item(OP_WRITE, s, RAND_W'($urandom), h, d);
	endtask

	task automatic read_site(input logic [SITE_W-1:0] s);
		send_item(OP_READ, s, RAND_W'($urandom), $urandom, 1'($urandom));
	endtask

	task automatic update_site(input logic [SITE_W-1:0] s, input logic [RAND_W-1:0] rf);
		send_item(OP_UPDATE, s, rf, $urandom, 1'($urandom));
	endtask

	// Random fraction for an update. Half are uniform; the rest sit on the
	// extremes or at or just below one of the programmed thresholds.
	function automatic logic [RAND_W-1:0] pick_frac();
		logic [PROB_REG_W-1:0] p;
		p = cur_prob[$urandom_range(0, 3)];
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return p[RAND_W-1:0];
			3: return p[RAND_W-1:0] - 1'b1;
			default: return RAND_W'($urandom);
		endcase
	endfunction

	// Stops sending and waits until every predicted result has come back.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PROB_REG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Programs all registers for one phase. The block is idle first, since
	// configuration may only change with no item in flight.
	task automatic program_phase(input int p);
		logic en;
		drain();
		case (p)
			0: begin
				cur_prob = '{17'h08000, 17'h04000, 17'h08000, 17'h0C000};
				en = 1'b1;
			end
			1: begin
				// Never, exactly full scale, the largest register value, never.
				cur_prob = '{17'h00000, 17'h10000, 17'h1FFFF, 17'h00000};
				en = 1'b1;
			end
			2: begin
				// Disorder off: the disordered values must have no effect.
				cur_prob = '{17'h10000, 17'h1FFFF, 17'h0FFFF, 17'h00001};
				en = 1'b0;
			end
			3: begin
				foreach (cur_prob[k])
					cur_prob[k] = PROB_REG_W'($urandom);
				en = 1'($urandom);
			end
			4: begin
				cur_prob = '{17'h0FFFF, 17'h00001, 17'h10000, 17'h0FFFF};
				en = 1'b1;
			end
			default: begin
				cur_prob = '{17'h0C000, 17'h02000, 17'h06000, 17'h0E000};
				en = 1'b1;
			end
		endcase
		write_reg(CFG_RISE_CLEAN, cur_prob[0]);
		write_reg(CFG_RISE_DIS,   cur_prob[1]);
		write_reg(CFG_FALL_CLEAN, cur_prob[2]);
		write_reg(CFG_FALL_DIS,   cur_prob[3]);
		// Only bit 0 of the enable register counts; the upper data bits carry noise.
		write_reg(CFG_DIS_EN, {(PROB_REG_W-1)'($urandom), en});
		if (p == 1)
			write_reg(CFG_SPARE, PROB_REG_W'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int                kind;
		int                seg_len;
		int                n_upd;
		int                sel;
		int                goal;
		int                items_before;
		logic [SITE_W-1:0] base;
		logic [SITE_W-1:0] s;
		logic [SITE_W-1:0] lft;
		logic [SITE_W-1:0] rgt;
		logic [IN_H_W-1:0] h;

		arst_n       = 1'b0;
		start        = 1'b0;
		op           = OP_READ;
		site         = '0;
		random_frac  = '0;
		new_height   = '0;
		new_disorder = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_RISE_CLEAN;
		cfg_data     = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			quiet = (p == PHASES - 1);
			calm  = quiet;
			program_phase(p);

			if (p == 0) begin
				// Directed part. Rise on disordered sites uses 0x4000, fall on
				// disordered sites 0xC000, clean sites 0x8000 both ways.
				// Local minimum at site 0 whose left neighbor wraps to the top
				// of the ring; site 0 is disordered.
				write_site(13'd8191, 32'd1, 1'b0);
				write_site(13'd0, 32'd0, 1'b1);
				write_site(13'd1, 32'd1, 1'b0);
				read_site(13'd0);
				update_site(13'd0, 16'h0000);
				// Now a local maximum: it falls back.
				update_site(13'd0, 16'h0000);
				// Minimum again, but the fraction is far above the rise threshold.
				update_site(13'd0, 16'hFFFF);
				send_item(OP_SPARE, 13'd0, 16'hFFFF, 32'h5A5A_A5A5, 1'b1);
				// Minimum whose neighbors sit across the signed overflow point.
				write_site(13'd100, 32'h8000_0000, 1'b0);
				write_site(13'd101, 32'h7FFF_FFFF, 1'b0);
				write_site(13'd102, 32'h8000_0000, 1'b1);
				update_site(13'd101, 16'h7FFF);
				update_site(13'd101, 16'h7FFF);
				// A fraction equal to the probability must not succeed.
				update_site(13'd101, 16'h8000);
				// Minimum at -1 rising through zero on a disordered site.
				write_site(13'd200, 32'h0000_0000, 1'b0);
				write_site(13'd201, 32'hFFFF_FFFF, 1'b1);
				write_site(13'd202, 32'h0000_0000, 1'b1);
				update_site(13'd201, 16'h3FFF);
				// Site 8191 on a plain downward slope, right neighbor wrapping
				// to site 0: no change.
				write_site(13'd8190, 32'd2, 1'b1);
				update_site(13'd8191, 16'h0000);
				read_site(13'd8191);
			end

			// Random part. Most stretches lay down a short single-step segment
			// of the surface and hammer its interior with updates, so minima
			// and maxima come up all the time; the rest are stray writes,
			// reads, spare ops and updates on older sites.
			goal = PHASE_ITEMS;
			items_before = 0;
			while (items_before < goal) begin
				kind = $urandom_range(0, 9);
				calm = quiet || ($urandom_range(0, 3) == 0);
				if (kind <= 6) begin
					seg_len = $urandom_range(3, 10);
					if (kind == 6)
						base = SITE_W'(RING_SITES - $urandom_range(1, seg_len));
					else
						base = SITE_W'($urandom);
					case ($urandom_range(0, 3))
						0: h = 32'h7FFF_FFFF - $urandom_range(0, 8);
						1: h = 32'hFFFF_FFFF - $urandom_range(0, 8);
						default: h = $urandom;
					endcase
					for (int k = 0; k < seg_len; k++) begin
						write_site(base + SITE_W'(k), h, 1'($urandom));
						h = $urandom_range(0, 1) ? h + 1 : h - 1;
					end
					n_upd = $urandom_range(seg_len, 4 * seg_len);
					items_before += seg_len + n_upd;
					repeat (n_upd) begin
						s   = base + SITE_W'($urandom_range(1, seg_len - 2));
						sel = $urandom_range(0, 11);
						if (sel == 0)
							read_site(base + SITE_W'($urandom_range(0, seg_len - 1)));
						else if (sel == 1)
							// Breaks the single-step shape on purpose.
							write_site(s, $urandom, 1'($urandom));
						else
							update_site(s, pick_frac());
					end
				end else if (kind == 7) begin
					s = SITE_W'($urandom);
					write_site(s, $urandom, 1'($urandom));
					read_site(s);
					items_before += 2;
				end else begin
					s   = written_sites[$urandom_range(0, written_sites.size() - 1)];
					lft = s - 1'b1;
					rgt = s + 1'b1;
					if (kind == 9 && site_written[lft] && site_written[rgt])
						update_site(s, pick_frac());
					else if ($urandom_range(0, 1) == 0)
						send_item(OP_SPARE, s, RAND_W'($urandom), $urandom, 1'($urandom));
					else
						read_site(s);
					items_before += 1;
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("single_step_growth_update_top_test passed");
		else
			$display("single_step_growth_update_top_test failed");
		$finish;
	end

endmodule

>>> sim.f
sv/ssgu_pkg.sv
sv/ssgu_queue.sv
sv/ssgu_front.sv
sv/ssgu_back.sv
sv/single_step_growth_update_top.sv
dv/ssgu_checker.sv
dv/single_step_growth_update_top_test.sv
